>>> rtl/iemt_pkg.sv
`default_nettype none
package iemt_pkg;

  // Fixed widths of the channel fields.
  localparam int FIELD_W  = 48;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 5;

  // Largest block count one extent may hold.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Request kinds.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SPILL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_RESULT
  } state_e;

  // What the rewrite pass does to the table.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MERGE,
    ACT_APPEND,
    ACT_SPARSE,
    ACT_SPLIT
  } act_e;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] file_block;
    logic [FIELD_W-1:0] phys_start;
    logic [COUNT_W-1:0] run_length;
    logic               unwritten_mark;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  phys_block;
    logic [FIELD_W-1:0]  run_left;
    logic                run_unbounded;
    logic                is_unwritten;
    logic [USED_W-1:0]   entries_used;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/iemt_if.sv
`default_nettype none
// Request channel: one beat is one lookup or insert.
interface iemt_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [iemt_pkg::FIELD_W-1:0]     file_block;
  logic [iemt_pkg::FIELD_W-1:0]     phys_start;
  logic [iemt_pkg::COUNT_W-1:0]     run_length;
  logic                             unwritten_mark;

  modport source (output valid, req_type, file_block, phys_start, run_length,
                  unwritten_mark, input ready);
  modport sink   (input valid, req_type, file_block, phys_start, run_length,
                  unwritten_mark, output ready);
endinterface

// Response channel: one beat per request.
interface iemt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [iemt_pkg::STATUS_W-1:0]    status;
  logic [iemt_pkg::FIELD_W-1:0]     phys_block;
  logic [iemt_pkg::FIELD_W-1:0]     run_left;
  logic                             run_unbounded;
  logic                             is_unwritten;
  logic [iemt_pkg::USED_W-1:0]      entries_used;

  modport source (output valid, status, phys_block, run_left, run_unbounded,
                  is_unwritten, entries_used, input ready);
  modport sink   (input valid, status, phys_block, run_left, run_unbounded,
                  is_unwritten, entries_used, output ready);
endinterface
`default_nettype wire

>>> rtl/inline_extent_map_table_core.sv
`default_nettype none
// A lookup scans the ring once (SCAN), then gives its response beat (RESULT); an insert
// scans, decides (DECIDE) and, if it changes the table, rewrites the ring in a second pass
// (WRITE) before RESULT. One request at a time: the next is accepted in IDLE once the
// response beat is issued; the ring rotates once per pass, one entry per cycle.
// Reset clears the entry count and the control; entry contents stay undefined.
module inline_extent_map_table_core #(
  parameter int MAX_EXTENTS     = 16,
  parameter int BLOCK_ADDR_BITS = 48
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  iemt_req_if.sink   req_i,
  iemt_rsp_if.source rsp_o
);

  localparam int AW  = BLOCK_ADDR_BITS;
  localparam int CNW = iemt_pkg::COUNT_W;
  localparam int TW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int NW  = $clog2(MAX_EXTENTS + 1);
  localparam int CW  = iemt_pkg::FIELD_W + 2;
  localparam int QD  = 4;
  localparam int CL  = QD + 1;

  typedef struct packed {
    logic [AW-1:0]  st;
    logic [CNW-1:0] cnt;
    logic           uw;
  } ent_t;

  // Control state.
  iemt_pkg::state_e state_q, state_d;
  iemt_pkg::act_e   act_q, act_d;
  logic [NW-1:0]    n_q, n_d, nnew_q, nnew_d;
  logic [TW-1:0]    t_q, t_d;
  logic             found_q, found_d;
  logic [2:0]       qc_q, qc_d;
  logic             rsp_valid_q, rsp_valid_d;

  // Payload state.
  iemt_pkg::req_t   req_q, req_d;
  iemt_pkg::rsp_t   rsp_q, rsp_d;
  logic [CW-1:0]    off_q, off_d, hs_q, hs_d, fend_q, fend_d;
  logic [TW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    fst_q, fst_d, lst_q, lst_d;
  logic [CNW-1:0]   fcnt_q, fcnt_d, lcnt_q, lcnt_d;
  logic             fuw_q, fuw_d, luw_q, luw_d;
  logic [CNW-1:0]   pre_q, pre_d, post_q, post_d;
  logic [iemt_pkg::STATUS_W-1:0] stat_q, stat_d;
  ent_t             q_q [QD];
  ent_t             q_d [QD];

  // Cell ring.
  ent_t cell_in  [MAX_EXTENTS];
  ent_t cell_out [MAX_EXTENTS];
  ent_t head, tail;
  logic shift_en;
  logic req_ready;

  for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
    if (k == MAX_EXTENTS - 1) begin : g_top
      assign cell_in[k] = tail;
    end else begin : g_mid
      assign cell_in[k] = cell_out[k + 1];
    end
    iemt_cell #(.AddrW(AW)) u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en),
      .start_i    (cell_in[k].st),
      .count_i    (cell_in[k].cnt),
      .uw_i       (cell_in[k].uw),
      .start_o    (cell_out[k].st),
      .count_o    (cell_out[k].cnt),
      .uw_o       (cell_out[k].uw)
    );
  end

  assign head = cell_out[0];

  // Next state, table rewrite stream and result.
  always_comb begin
    logic [CW-1:0]   fblk, cntr, h_end, gap, hole_end, fo_end;
    logic [AW-1:0]   st_in;
    logic            tvalid, merge_ok;
    logic [CNW:0]    msum;
    logic [NW+1:0]   ne2, te2, need, pre_nz, post_nz;
    logic [CNW-1:0]  pre_v, post_v;
    ent_t            new_ent, push [3];
    ent_t            cl [CL];
    logic [1:0]      pc;
    logic [2:0]      pj;

    state_d     = state_q;
    act_d       = act_q;
    n_d         = n_q;
    nnew_d      = nnew_q;
    t_d         = t_q;
    found_d     = found_q;
    qc_d        = qc_q;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    req_d       = req_q;
    rsp_d       = rsp_q;
    off_d       = off_q;
    hs_d        = hs_q;
    fend_d      = fend_q;
    idx_d       = idx_q;
    fst_d       = fst_q;
    fcnt_d      = fcnt_q;
    fuw_d       = fuw_q;
    lst_d       = lst_q;
    lcnt_d      = lcnt_q;
    luw_d       = luw_q;
    pre_d       = pre_q;
    post_d      = post_q;
    stat_d      = stat_q;
    for (int j = 0; j < QD; j++) q_d[j] = q_q[j];
    shift_en    = 1'b0;
    tail        = head;
    req_ready   = 1'b0;

    fblk    = CW'(req_q.file_block);
    cntr    = CW'(req_q.run_length);
    st_in   = AW'(req_q.phys_start);
    h_end   = off_q + CW'(head.cnt);
    tvalid  = NW'(t_q) < n_q;
    new_ent = '{st: st_in, cnt: req_q.run_length, uw: req_q.unwritten_mark};
    ne2     = (NW+2)'(n_q);
    te2     = (NW+2)'(t_q);
    gap      = fblk - off_q;
    hole_end = hs_q + CW'(fcnt_q);
    fo_end   = fblk + cntr;
    msum     = {1'b0, lcnt_q} + {1'b0, req_q.run_length};
    merge_ok = (n_q != '0) && (lst_q != '0) && (luw_q == req_q.unwritten_mark) &&
               (AW'(lst_q + AW'(lcnt_q)) == st_in) && !msum[CNW];
    pre_v    = CNW'(fblk - hs_q);
    post_v   = CNW'(hole_end - fo_end);
    pre_nz   = (NW+2)'(pre_v != '0);
    post_nz  = (NW+2)'(post_v != '0);
    need     = (NW+2)'(1) + pre_nz + post_nz;

    // Rewrite stream: what enters the ring for the entry now at the head.
    for (int j = 0; j < 3; j++) push[j] = head;
    pc = 2'd1;
    case (act_q)
      iemt_pkg::ACT_MERGE: begin
        if (te2 == ne2 - 1'b1) push[0].cnt = head.cnt + req_q.run_length;
      end
      iemt_pkg::ACT_APPEND: begin
        if (te2 == ne2) push[0] = new_ent;
      end
      iemt_pkg::ACT_SPARSE: begin
        if (te2 == ne2) push[0] = '{st: '0, cnt: pre_q, uw: 1'b0};
        else if (te2 == ne2 + 1'b1) push[0] = new_ent;
      end
      iemt_pkg::ACT_SPLIT: begin
        if (t_q == idx_q) begin
          if (pre_q != '0) begin
            push[0] = '{st: '0, cnt: pre_q, uw: 1'b0};
            push[1] = new_ent;
            push[2] = '{st: '0, cnt: post_q, uw: 1'b0};
            pc      = (post_q != '0) ? 2'd3 : 2'd2;
          end else begin
            push[0] = new_ent;
            push[1] = '{st: '0, cnt: post_q, uw: 1'b0};
            pc      = (post_q != '0) ? 2'd2 : 2'd1;
          end
        end
      end
      default: ;
    endcase

    // Queue ahead of the ring tail absorbs the entries a split adds.
    for (int j = 0; j < CL; j++) begin
      pj    = 3'(j) - qc_q;
      cl[j] = head;
      if (3'(j) < qc_q) cl[j] = q_q[j];
      else if (pj < 3'(pc)) cl[j] = push[pj[1:0]];
    end

    case (state_q)
      iemt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          req_d   = '{req_type: req_i.req_type, file_block: req_i.file_block,
                      phys_start: req_i.phys_start, run_length: req_i.run_length,
                      unwritten_mark: req_i.unwritten_mark};
          off_d   = '0;
          found_d = 1'b0;
          t_d     = '0;
          state_d = iemt_pkg::ST_SCAN;
        end
      end
      iemt_pkg::ST_SCAN: begin
        // Rotate once, keeping the running offset and the entries of interest.
        shift_en = 1'b1;
        tail     = head;
        if (tvalid) begin
          off_d = h_end;
          if (!found_q && (fblk < h_end)) begin
            found_d = 1'b1;
            idx_d   = t_q;
            hs_d    = off_q;
            fend_d  = h_end;
            fst_d   = head.st;
            fcnt_d  = head.cnt;
            fuw_d   = head.uw;
          end
          if (NW'(t_q) == n_q - 1'b1) begin
            lst_d  = head.st;
            lcnt_d = head.cnt;
            luw_d  = head.uw;
          end
        end
        t_d = t_q + 1'b1;
        if (t_q == TW'(MAX_EXTENTS - 1)) begin
          t_d     = '0;
          state_d = (req_q.req_type == iemt_pkg::REQ_INSERT) ? iemt_pkg::ST_DECIDE
                                                             : iemt_pkg::ST_RESULT;
        end
      end
      iemt_pkg::ST_DECIDE: begin
        act_d  = iemt_pkg::ACT_NONE;
        stat_d = iemt_pkg::STATUS_OK;
        nnew_d = n_q;
        if ((cntr == '0) || (st_in == '0)) begin
          stat_d = iemt_pkg::STATUS_INVALID;
        end else if (fblk == off_q) begin
          // Insert at the mapped end.
          if (merge_ok) begin
            act_d = iemt_pkg::ACT_MERGE;
          end else if (ne2 >= (NW+2)'(MAX_EXTENTS)) begin
            stat_d = iemt_pkg::STATUS_SPILL;
          end else begin
            act_d  = iemt_pkg::ACT_APPEND;
            nnew_d = NW'(ne2 + 1'b1);
          end
        end else if (fblk > off_q) begin
          // Insert past the end: a hole, then the data.
          if ((ne2 + (NW+2)'(2) > (NW+2)'(MAX_EXTENTS)) ||
              (gap > CW'(iemt_pkg::COUNT_MAX))) begin
            stat_d = iemt_pkg::STATUS_SPILL;
          end else begin
            act_d  = iemt_pkg::ACT_SPARSE;
            pre_d  = CNW'(gap);
            nnew_d = NW'(ne2 + (NW+2)'(2));
          end
        end else begin
          // Insert inside the map: must lie wholly in one hole.
          if (!found_q || (fst_q != '0) || (fo_end > hole_end)) begin
            stat_d = iemt_pkg::STATUS_INVALID;
          end else if (ne2 - 1'b1 + need > (NW+2)'(MAX_EXTENTS)) begin
            stat_d = iemt_pkg::STATUS_SPILL;
          end else begin
            act_d  = iemt_pkg::ACT_SPLIT;
            pre_d  = pre_v;
            post_d = post_v;
            nnew_d = NW'(ne2 - 1'b1 + need);
          end
        end
        t_d     = '0;
        qc_d    = '0;
        state_d = (act_d == iemt_pkg::ACT_NONE) ? iemt_pkg::ST_RESULT
                                                : iemt_pkg::ST_WRITE;
      end
      iemt_pkg::ST_WRITE: begin
        shift_en = 1'b1;
        tail     = cl[0];
        for (int j = 0; j < QD; j++) q_d[j] = cl[j + 1];
        qc_d = qc_q + 3'(pc) - 3'd1;
        t_d  = t_q + 1'b1;
        if (t_q == TW'(MAX_EXTENTS - 1)) begin
          t_d     = '0;
          n_d     = nnew_q;
          state_d = iemt_pkg::ST_RESULT;
        end
      end
      iemt_pkg::ST_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '0;
          rsp_d.entries_used = iemt_pkg::USED_W'(n_q);
          if (req_q.req_type == iemt_pkg::REQ_INSERT) begin
            rsp_d.status = stat_q;
          end else if (found_q) begin
            rsp_d.status   = iemt_pkg::STATUS_OK;
            rsp_d.run_left = iemt_pkg::FIELD_W'(fend_q - fblk);
            if (fst_q != '0) begin
              rsp_d.phys_block   = iemt_pkg::FIELD_W'(AW'(fst_q + AW'(fblk - hs_q)));
              rsp_d.is_unwritten = fuw_q;
            end
          end else begin
            rsp_d.status        = iemt_pkg::STATUS_OK;
            rsp_d.run_left      = '1;
            rsp_d.run_unbounded = 1'b1;
          end
          state_d = iemt_pkg::ST_IDLE;
        end
      end
      default: state_d = iemt_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iemt_pkg::ST_IDLE;
      act_q       <= iemt_pkg::ACT_NONE;
      n_q         <= '0;
      nnew_q      <= '0;
      t_q         <= '0;
      found_q     <= 1'b0;
      qc_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      n_q         <= n_d;
      nnew_q      <= nnew_d;
      t_q         <= t_d;
      found_q     <= found_d;
      qc_q        <= qc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    off_q  <= off_d;
    hs_q   <= hs_d;
    fend_q <= fend_d;
    idx_q  <= idx_d;
    fst_q  <= fst_d;
    fcnt_q <= fcnt_d;
    fuw_q  <= fuw_d;
    lst_q  <= lst_d;
    lcnt_q <= lcnt_d;
    luw_q  <= luw_d;
    pre_q  <= pre_d;
    post_q <= post_d;
    stat_q <= stat_d;
    for (int j = 0; j < QD; j++) q_q[j] <= q_d[j];
  end

  // Ports.
  assign req_i.ready         = req_ready;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.phys_block    = rsp_q.phys_block;
  assign rsp_o.run_left      = rsp_q.run_left;
  assign rsp_o.run_unbounded = rsp_q.run_unbounded;
  assign rsp_o.is_unwritten  = rsp_q.is_unwritten;
  assign rsp_o.entries_used  = rsp_q.entries_used;

  // The entry count never passes the ring length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_EXTENTS))
    else $error("entry count above table size");

  // A rewrite pass only runs for a decided table change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iemt_pkg::ST_WRITE |-> act_q != iemt_pkg::ACT_NONE)
    else $error("rewrite pass without an action");

  // A lookup scan leaves the entry count alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iemt_pkg::ST_SCAN) && (req_q.req_type == iemt_pkg::REQ_LOOKUP)
    |=> $stable(n_q))
    else $error("lookup changed the entry count");

  // The split queue never holds more than two waiting entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iemt_pkg::ST_WRITE |-> qc_q <= 3'd2)
    else $error("split queue overflow");

endmodule
`default_nettype wire

>>> rtl/iemt_cell.sv
`default_nettype none
// One table entry. On a shift it takes the entry of its upper neighbor.
module iemt_cell #(
  parameter int AddrW = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         shift_en_i,
  input  wire logic [AddrW-1:0]             start_i,
  input  wire logic [iemt_pkg::COUNT_W-1:0] count_i,
  input  wire logic                         uw_i,
  output logic      [AddrW-1:0]             start_o,
  output logic      [iemt_pkg::COUNT_W-1:0] count_o,
  output logic                              uw_o
);

  logic [AddrW-1:0]             start_q;
  logic [iemt_pkg::COUNT_W-1:0] count_q;
  logic                         uw_q;

  // Entry storage, contents undefined until first written.
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      start_q <= start_i;
      count_q <= count_i;
      uw_q    <= uw_i;
    end
  end

  assign start_o = start_q;
  assign count_o = count_q;
  assign uw_o    = uw_q;

endmodule
`default_nettype wire
